[sv/pwm_input_duty_frequency_meter_assert.svh]
// ----------------------------------------------------------------------------
// PWM meter assertion macros
// Concurrent assertion shorthands shared by the meter RTL.
// ----------------------------------------------------------------------------
`ifndef PWM_INPUT_DUTY_FREQUENCY_METER_ASSERT_SVH
`define PWM_INPUT_DUTY_FREQUENCY_METER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define PIDFM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define PIDFM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/pidfm_pkg.sv]
// ----------------------------------------------------------------------------
// PWM meter package
// Widths, reset values and codes shared by the meter and its divider.
// ----------------------------------------------------------------------------
package pidfm_pkg;

	localparam int COUNT_WIDTH_DEF = 16;

	localparam int CLK_W    = 27;
	localparam int LIMIT_W  = 16;
	localparam int DUTY_W   = 7;
	localparam int QUOT_W   = 27;
	localparam int STEP_W   = 5;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;

	localparam logic [CLK_W-1:0]   CORE_CLOCK_RESET   = 27'd24000000;
	localparam logic [LIMIT_W-1:0] PERIOD_LIMIT_RESET = 16'd19999;
	localparam logic [DUTY_W-1:0]  DUTY_SCALE         = 7'd100;

	// quotient bits produced by each division
	localparam logic [STEP_W-1:0] DUTY_STEPS = 5'd7;
	localparam logic [STEP_W-1:0] FREQ_STEPS = 5'd27;

	// register index, taken from paddr[2]
	localparam logic REG_CORE_CLOCK   = 1'b0;
	localparam logic REG_PERIOD_LIMIT = 1'b1;

endpackage

[sv/pidfm_div.sv]
// ----------------------------------------------------------------------------
// PWM meter shared divider
// Restoring shift-subtract divider, one quotient bit per cycle. Starts from a
// given partial remainder and shifts in up to QUOT_W numerator bits, MSB first.
// ----------------------------------------------------------------------------
module pidfm_div
	import pidfm_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [COUNT_WIDTH:0]   rem_init,
	input  logic [QUOT_W-1:0]      num,
	input  logic [STEP_W-1:0]      steps,
	input  logic [COUNT_WIDTH:0]   den,
	output logic                   busy,
	output logic                   done,
	output logic [QUOT_W-1:0]      quot
);

	localparam int RW = COUNT_WIDTH + 1;

	logic [RW-1:0]     rem_q;
	logic [RW-1:0]     den_q;
	logic [QUOT_W-1:0] num_q;
	logic [QUOT_W-1:0] quot_q;
	logic [STEP_W-1:0] cnt_q;
	logic              done_q;

	logic [RW:0]       shifted;
	logic [RW:0]       den_ext;
	logic [RW:0]       diff;
	logic              ge;

	assign shifted = {rem_q, num_q[QUOT_W-1]};
	assign den_ext = {1'b0, den_q};
	assign ge      = (shifted >= den_ext);
	assign diff    = shifted - den_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			den_q  <= '0;
			num_q  <= '0;
			quot_q <= '0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= rem_init;
				den_q  <= den;
				num_q  <= num;
				quot_q <= '0;
				cnt_q  <= steps;
			end else if (cnt_q != '0) begin
				// remainder stays below the divisor, so RW bits hold it
				rem_q  <= ge ? diff[RW-1:0] : shifted[RW-1:0];
				num_q  <= {num_q[QUOT_W-2:0], 1'b0};
				quot_q <= {quot_q[QUOT_W-2:0], ge};
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == STEP_W'(1));
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign done = done_q;
	assign quot = quot_q;

endmodule

[sv/pwm_input_duty_frequency_meter.sv]
// Sequencing: a tick without a rising edge is handled in ST_IDLE; a rising edge runs the
// duty, then the frequency division (7 and 27 quotient bits) on one shared shift-subtract
// divider, then registers the result. Saturated duty skips the first, zero period both.
// Throughput: item_stall is high from a rising edge until its result is registered.
// Reset: arst_n clears the counter, captures and handshake state at once and
// loads core_clock 24000000 and period_limit 19999.
// ----------------------------------------------------------------------------
// PWM input duty and frequency meter
// Counts prescaled ticks, captures high time and period from pin edges and
// reports duty percent and frequency on each rising edge.
// ----------------------------------------------------------------------------
`include "pwm_input_duty_frequency_meter_assert.svh"

module pwm_input_duty_frequency_meter
	import pidfm_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	// tick transactions
	input  logic              item_valid,
	output logic              item_stall,
	input  logic              pin_level,
	// result transactions
	output logic              result_valid,
	input  logic              result_stall,
	output logic [DUTY_W-1:0] duty_percent,
	output logic [CLK_W-1:0]  frequency,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	localparam int CW   = COUNT_WIDTH;
	localparam int RW   = CW + 1;
	localparam int NW   = CW + DUTY_W;
	localparam int CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DUTY,
		ST_FREQ,
		ST_FIN
	} state_t;

	state_t            state_q;
	logic [CLK_W-1:0]  core_clock_q;
	logic [LIMIT_W-1:0] period_limit_q;
	logic              prev_level_q;
	logic [CW-1:0]     tick_count_q;
	logic [CW-1:0]     high_capture_q;
	logic [DUTY_W-1:0] duty_q;
	logic [CLK_W-1:0]  freq_q;
	logic              result_valid_q;
	logic [DUTY_W-1:0] duty_out_q;
	logic [CLK_W-1:0]  freq_out_q;

	logic              div_start_q;
	logic [RW-1:0]     div_rem_q;
	logic [QUOT_W-1:0] div_num_q;
	logic [STEP_W-1:0] div_steps_q;
	logic [RW-1:0]     div_den_q;
	logic              div_busy;
	logic              div_done;
	logic [QUOT_W-1:0] div_quot;

	logic              accept;
	logic              rising;
	logic              falling;
	logic              at_limit;
	logic [NW-1:0]     duty_num;
	logic              cfg_write;

	assign pready     = 1'b1;
	assign cfg_write  = psel && penable && pwrite;
	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign rising     = !prev_level_q && pin_level;
	assign falling    = prev_level_q && !pin_level;
	assign at_limit   = (CMPW'(tick_count_q) >= CMPW'(period_limit_q));

	// high time times 100 as shifts and adds
	assign duty_num = (NW'(high_capture_q) << 6) + (NW'(high_capture_q) << 5)
		+ (NW'(high_capture_q) << 2);

	always_comb begin
		prdata = '0;
		case (paddr[2])
			REG_CORE_CLOCK:   prdata = DATA_W'(core_clock_q);
			REG_PERIOD_LIMIT: prdata = DATA_W'(period_limit_q);
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			core_clock_q   <= CORE_CLOCK_RESET;
			period_limit_q <= PERIOD_LIMIT_RESET;
		end else if (cfg_write) begin
			case (paddr[2])
				REG_CORE_CLOCK:   core_clock_q   <= pwdata[CLK_W-1:0];
				REG_PERIOD_LIMIT: period_limit_q <= pwdata[LIMIT_W-1:0];
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			prev_level_q   <= 1'b0;
			tick_count_q   <= '0;
			high_capture_q <= '0;
			duty_q         <= '0;
			freq_q         <= '0;
			result_valid_q <= 1'b0;
			duty_out_q     <= '0;
			freq_out_q     <= '0;
			div_start_q    <= 1'b0;
			div_rem_q      <= '0;
			div_num_q      <= '0;
			div_steps_q    <= '0;
			div_den_q      <= '0;
		end else begin
			div_start_q <= 1'b0;
			if (result_valid_q && !result_stall && (state_q != ST_FIN)) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						prev_level_q <= pin_level;
						if (!rising) begin
							if (falling) begin
								high_capture_q <= tick_count_q;
							end
							tick_count_q <= at_limit ? '0 : tick_count_q + 1'b1;
						end else begin
							tick_count_q <= '0;
							if (tick_count_q == '0) begin
								duty_q  <= '0;
								freq_q  <= '0;
								state_q <= ST_FIN;
							end else if (high_capture_q >= tick_count_q) begin
								// saturate duty, go straight to frequency
								duty_q      <= DUTY_SCALE;
								div_start_q <= 1'b1;
								div_rem_q   <= '0;
								div_num_q   <= core_clock_q;
								div_steps_q <= FREQ_STEPS;
								div_den_q   <= RW'(tick_count_q) + 1'b1;
								state_q     <= ST_FREQ;
							end else begin
								div_start_q <= 1'b1;
								div_rem_q   <= RW'(duty_num[NW-1:DUTY_W]);
								div_num_q   <= {duty_num[DUTY_W-1:0],
									(QUOT_W-DUTY_W)'(0)};
								div_steps_q <= DUTY_STEPS;
								div_den_q   <= RW'(tick_count_q);
								state_q     <= ST_DUTY;
							end
						end
					end
				end
				ST_DUTY: begin
					if (div_done) begin
						duty_q      <= div_quot[DUTY_W-1:0];
						div_start_q <= 1'b1;
						div_rem_q   <= '0;
						div_num_q   <= core_clock_q;
						div_steps_q <= FREQ_STEPS;
						// frequency divides by period plus one
						div_den_q   <= div_den_q + 1'b1;
						state_q     <= ST_FREQ;
					end
				end
				ST_FREQ: begin
					if (div_done) begin
						freq_q  <= div_quot[CLK_W-1:0];
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// hold until the output register is free
					if (!result_valid_q || !result_stall) begin
						result_valid_q <= 1'b1;
						duty_out_q     <= duty_q;
						freq_out_q     <= freq_q;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	pidfm_div #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.rem_init (div_rem_q),
		.num      (div_num_q),
		.steps    (div_steps_q),
		.den      (div_den_q),
		.busy     (div_busy),
		.done     (div_done),
		.quot     (div_quot)
	);

	assign result_valid = result_valid_q;
	assign duty_percent = duty_out_q;
	assign frequency    = freq_out_q;

	`PIDFM_ASSERT_IMP(a_duty_range, clk, arst_n, result_valid, duty_percent <= DUTY_SCALE, "duty above scale")
	`PIDFM_ASSERT_IMP(a_result_from_fin, clk, arst_n, $rose(result_valid), $past(state_q == ST_FIN), "result without finish")
	`PIDFM_ASSERT_NEXT(a_div_starts, clk, arst_n, div_start_q, div_busy, "divider did not start")

endmodule
